// ===== hdl/csv_field_tokenizer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// Clocked check, muted while reset is held.
`define CSVT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also runs during reset.
`define CSVT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csvt_pkg;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_END     = 2'd1,
        KIND_DISCARD = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    localparam logic ERR_STRAY_QUOTE  = 1'b0;
    localparam logic ERR_UNTERMINATED = 1'b1;

    typedef enum logic [2:0] {
        MODE_UNQUOTED = 3'b001,
        MODE_QUOTED   = 3'b010,
        MODE_QSEEN    = 3'b100
    } mode_t;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] FIELD_MAX  = 8'hFF;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_byte;
        logic       line_end;
    } in_beat_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       error_code;
        logic [7:0] field_number;
        logic       end_of_line;
        logic       last_of_run;
    } out_beat_t;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Splits a line of bytes into comma-separated fields with quoting.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per byte (has_byte) with a line_end flag; a beat
//   with has_byte low and line_end high is a bare line end, a beat with both
//   low is ignored.
//   m_ channel: result beats (data byte, field end, discard marker, error),
//   each tagged with its field number; last_of_run marks the final result
//   of one input beat.
//   Results of a beat are at the m_ port the cycle after it is accepted.
//   One input beat per cycle is taken while every beat gives at most one
//   result and m_ready stays high; after a beat giving two results, the
//   next beat waits until the two-entry result buffer has passed one on.
//   Reset empties the result buffer and returns the parser to an unquoted
//   first field. When the receiver stalls, results wait in the buffer and
//   s_ready drops once the buffer cannot take another beat's results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csv_field_tokenizer
    import csvt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    mode_t      mode_reg, mode_next;
    logic       nonblank_reg, nonblank_next;
    logic       failed_reg, failed_next;
    logic [7:0] field_reg, field_next;

    out_beat_t  slot0_reg, slot0_next;
    out_beat_t  slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       accept;
    logic       pop;

    out_beat_t  res_a, res_b;
    logic       res_a_vld, res_b_vld;

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = slot0_reg;
    assign pop     = m_valid && m_ready;
    // buffer must be empty after this cycle's pop to take up to two results
    assign s_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign accept  = s_valid && s_ready;

    // tokenizer step
    always_comb begin
        logic [7:0] c;
        logic       take;
        logic       unq;
        mode_t      m;
        logic       nb;
        logic       fl;
        logic [7:0] fc;

        c    = s_data.char_byte;
        take = s_data.has_byte && !failed_reg;
        m    = mode_reg;
        nb   = nonblank_reg;
        fl   = failed_reg;
        fc   = field_reg;
        unq  = 1'b0;

        res_a     = '0;
        res_b     = '0;
        res_a_vld = 1'b0;
        res_b_vld = 1'b0;
        res_a.field_number = field_reg;

        if (take) begin
            unique case (mode_reg)
                MODE_QSEEN: begin
                    if (c == CHAR_QUOTE) begin
                        res_a_vld       = 1'b1;
                        res_a.kind      = KIND_DATA;
                        res_a.data_byte = CHAR_QUOTE;
                        nb              = 1'b1;
                        m               = MODE_QUOTED;
                    end else begin
                        m   = MODE_UNQUOTED;
                        unq = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (c == CHAR_QUOTE) begin
                        m = MODE_QSEEN;
                    end else begin
                        res_a_vld       = 1'b1;
                        res_a.kind      = KIND_DATA;
                        res_a.data_byte = c;
                        if (!is_blank(c)) nb = 1'b1;
                    end
                end
                default: begin
                    unq = 1'b1;
                end
            endcase

            if (unq) begin
                res_a_vld = 1'b1;
                if (c == CHAR_COMMA) begin
                    res_a.kind = KIND_END;
                    if (fc != FIELD_MAX) fc = fc + 8'd1;
                    nb = 1'b0;
                end else if (c == CHAR_QUOTE) begin
                    if (nb) begin
                        res_a.kind       = KIND_ERROR;
                        res_a.error_code = ERR_STRAY_QUOTE;
                        fl               = 1'b1;
                    end else begin
                        res_a.kind = KIND_DISCARD;
                        m          = MODE_QUOTED;
                    end
                end else begin
                    res_a.kind      = KIND_DATA;
                    res_a.data_byte = c;
                    if (!is_blank(c)) nb = 1'b1;
                end
            end
        end

        if (s_data.line_end) begin
            if (!fl) begin
                res_b_vld          = 1'b1;
                res_b.field_number = fc;
                res_b.end_of_line  = 1'b1;
                if (m == MODE_QUOTED) begin
                    res_b.kind       = KIND_ERROR;
                    res_b.error_code = ERR_UNTERMINATED;
                end else begin
                    res_b.kind = KIND_END;
                end
            end else if (!failed_reg && res_a_vld) begin
                // stray quote on the line's last beat
                res_a.end_of_line = 1'b1;
            end
        end

        if (res_b_vld) res_b.last_of_run = 1'b1;
        else           res_a.last_of_run = 1'b1;

        if (s_data.line_end) begin
            mode_next     = MODE_UNQUOTED;
            nonblank_next = 1'b0;
            failed_next   = 1'b0;
            field_next    = '0;
        end else begin
            mode_next     = m;
            nonblank_next = nb;
            failed_next   = fl;
            field_next    = fc;
        end
    end

    // result buffer
    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (accept) begin
            // buffer is empty after the pop here
            if (res_a_vld) begin
                slot0_next = res_a;
                slot1_next = res_b;
            end else begin
                slot0_next = res_b;
            end
            cnt_next = {1'b0, res_a_vld} + {1'b0, res_b_vld};
        end else if (pop) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_UNQUOTED;
            nonblank_reg <= 1'b0;
            failed_reg   <= 1'b0;
            field_reg    <= '0;
            cnt_reg      <= 2'd0;
        end else begin
            if (accept) begin
                mode_reg     <= mode_next;
                nonblank_reg <= nonblank_next;
                failed_reg   <= failed_next;
                field_reg    <= field_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// ===== hdl/csvt_checker.sv =====
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks of the CSV field tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "csv_field_tokenizer_assert.svh"

module csvt_checker
    import csvt_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_beat_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_beat_t m_data
);

    logic s_stall;
    logic m_stall;
    logic m_eol;
    logic unused_ok;

    assign s_stall   = s_valid && !s_ready;
    assign m_stall   = m_valid && !m_ready;
    assign m_eol     = m_valid && m_data.end_of_line;
    // data byte only on data beats, error code only on error beats
    assign unused_ok = ((m_data.kind == KIND_DATA) || (m_data.data_byte == 8'h00)) &&
                       ((m_data.kind == KIND_ERROR) || !m_data.error_code);

    `CSVT_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result beat right after reset")

    `CSVT_ASSERT(a_in_hold, s_stall |=> s_valid && $stable(s_data), "waiting input beat changed")

    `CSVT_ASSERT(a_out_hold, m_stall |=> m_valid && $stable(m_data), "stalled beat changed")

    `CSVT_ASSERT(a_eol_last, m_eol |-> m_data.last_of_run, "line end not last of its run")

    `CSVT_ASSERT(a_unused_zero, m_valid |-> unused_ok, "unused result fields not zero")

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (.*);

`default_nettype wire
